### src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in a cycle implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// antecedent in a cycle implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### src/gpaf_pkg.sv
// ---------------------------------------------------------------------------
// gpaf_pkg
// Types and constants for the Gaussian-integer autocorrelation fingerprint.
// ---------------------------------------------------------------------------
package gpaf_pkg;

  // residue width: only the low three bits of each part matter mod 8
  localparam int unsigned ResW  = 3;
  localparam int unsigned ElemW = 2 * ResW;

  typedef struct packed {
    logic signed [3:0] elem_re;
    logic signed [3:0] elem_im;
  } in_t;

  typedef struct packed {
    logic [3:0]      shift_index;
    logic [ResW-1:0] corr_re_mod8;
    logic [ResW-1:0] corr_im_mod8;
    logic            last_of_run;
  } out_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CALC,
    ST_DRAIN,
    ST_EMIT
  } state_e;

endpackage

### src/gpaf_store.sv
// ---------------------------------------------------------------------------
// gpaf_store
// Element memory: one write port, two registered read ports.
// ---------------------------------------------------------------------------
module gpaf_store #(
  parameter int unsigned DEPTH = 21
) (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr_i,
  input  logic [gpaf_pkg::ElemW-1:0]    wr_data_i,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr_a_i,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr_b_i,
  output logic [gpaf_pkg::ElemW-1:0]    rd_data_a_o,
  output logic [gpaf_pkg::ElemW-1:0]    rd_data_b_o
);
  import gpaf_pkg::*;

  logic [ElemW-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_a_o <= mem_q[rd_addr_a_i];
    rd_data_b_o <= mem_q[rd_addr_b_i];
  end

endmodule

### src/gaussian_paf_mod8_fingerprint.sv
// While a word loads, its elements are written to the store in order.
// After the last element, each shift runs a multiply-accumulate pass
// over the word, one element pair per cycle from the two-port store,
// then a drain step and an emit step that holds its result until taken.
// Reset clears control; the element store is undefined until loaded.
// ---------------------------------------------------------------------------
// gaussian_paf_mod8_fingerprint
// Periodic autocorrelation of a Gaussian-integer word, reported mod 8.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gaussian_paf_mod8_fingerprint #(
  parameter int unsigned WORD_LENGTH = 21,
  parameter int unsigned NUM_SHIFTS  = 10
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  gpaf_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output gpaf_pkg::out_t out_data_o
);
  import gpaf_pkg::*;

  localparam int unsigned AW = $clog2(WORD_LENGTH);
  localparam int unsigned SW = $clog2(NUM_SHIFTS + 1);

  state_e          state_q, state_d;
  logic [AW-1:0]   load_q, load_d;
  logic [AW-1:0]   pos_q, pos_d;
  logic [AW-1:0]   qbase_q, qbase_d;
  logic [AW-1:0]   qpos_q, qpos_d;
  logic [SW-1:0]   shift_q, shift_d;
  logic [ResW-1:0] acc_re_q, acc_re_d;
  logic [ResW-1:0] acc_im_q, acc_im_d;
  logic            rd_vld_q;
  logic            out_vld_q, out_vld_d;
  out_t            out_q, out_d;

  logic             in_fire, out_fire;
  logic             wr_en;
  logic [ElemW-1:0] wr_data;
  logic [ElemW-1:0] rd_a, rd_b;
  logic [ResW-1:0]  ar, ai, br, bi;
  logic [2*ResW-1:0] m_rr, m_ii, m_ir, m_ri;
  logic [ResW-1:0]  term_re, term_im;
  logic [ResW-1:0]  sum_re, sum_im;
  logic             pos_last, shift_last;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_vld_q && out_ready_i;

  assign in_ready_o  = (state_q == ST_LOAD);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign wr_en   = in_fire;
  assign wr_data = {in_data_i.elem_re[ResW-1:0], in_data_i.elem_im[ResW-1:0]};

  gpaf_store #(
    .DEPTH (WORD_LENGTH)
  ) u_store (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (load_q),
    .wr_data_i   (wr_data),
    .rd_addr_a_i (pos_q),
    .rd_addr_b_i (qpos_q),
    .rd_data_a_o (rd_a),
    .rd_data_b_o (rd_b)
  );

  // w[p] * conj(w[q]), low three bits only
  assign ar = rd_a[ElemW-1:ResW];
  assign ai = rd_a[ResW-1:0];
  assign br = rd_b[ElemW-1:ResW];
  assign bi = rd_b[ResW-1:0];

  assign m_rr = ar * br;
  assign m_ii = ai * bi;
  assign m_ir = ai * br;
  assign m_ri = ar * bi;

  assign term_re = m_rr[ResW-1:0] + m_ii[ResW-1:0];
  assign term_im = m_ir[ResW-1:0] - m_ri[ResW-1:0];
  assign sum_re  = acc_re_q + term_re;
  assign sum_im  = acc_im_q + term_im;

  assign pos_last   = (pos_q == AW'(WORD_LENGTH - 1));
  assign shift_last = (shift_q == SW'(NUM_SHIFTS));

  always_comb begin
    state_d   = state_q;
    load_d    = load_q;
    pos_d     = pos_q;
    qbase_d   = qbase_q;
    qpos_d    = qpos_q;
    shift_d   = shift_q;
    acc_re_d  = acc_re_q;
    acc_im_d  = acc_im_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;

    if (rd_vld_q) begin
      acc_re_d = sum_re;
      acc_im_d = sum_im;
    end

    unique case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          if (load_q == AW'(WORD_LENGTH - 1)) begin
            load_d   = '0;
            shift_d  = SW'(1);
            qbase_d  = AW'(1);
            qpos_d   = AW'(1);
            pos_d    = '0;
            acc_re_d = '0;
            acc_im_d = '0;
            state_d  = ST_CALC;
          end else begin
            load_d = load_q + AW'(1);
          end
        end
      end
      ST_CALC: begin
        qpos_d = (qpos_q == AW'(WORD_LENGTH - 1)) ? '0 : qpos_q + AW'(1);
        if (pos_last) begin
          state_d = ST_DRAIN;
        end else begin
          pos_d = pos_q + AW'(1);
        end
      end
      ST_DRAIN: begin
        out_d.shift_index  = 4'(shift_q);
        out_d.corr_re_mod8 = sum_re;
        out_d.corr_im_mod8 = sum_im;
        out_d.last_of_run  = shift_last;
        out_vld_d          = 1'b1;
        state_d            = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_fire) begin
          out_vld_d = 1'b0;
          if (shift_last) begin
            state_d = ST_LOAD;
          end else begin
            shift_d  = shift_q + SW'(1);
            qbase_d  = (qbase_q == AW'(WORD_LENGTH - 1)) ? '0 : qbase_q + AW'(1);
            qpos_d   = (qbase_q == AW'(WORD_LENGTH - 1)) ? '0 : qbase_q + AW'(1);
            pos_d    = '0;
            acc_re_d = '0;
            acc_im_d = '0;
            state_d  = ST_CALC;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      load_q    <= '0;
      pos_q     <= '0;
      qbase_q   <= '0;
      qpos_q    <= '0;
      shift_q   <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      load_q    <= load_d;
      pos_q     <= pos_d;
      qbase_q   <= qbase_d;
      qpos_q    <= qpos_d;
      shift_q   <= shift_d;
      rd_vld_q  <= (state_q == ST_CALC);
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_re_q <= acc_re_d;
    acc_im_q <= acc_im_d;
    out_q    <= out_d;
  end

  `ASSERT_ALWAYS(a_no_overlap, !(in_ready_o && out_valid_o), "load and result overlap")
  `ASSERT_IMPLIES(a_rd_from_calc, rd_vld_q, $past(state_q == ST_CALC), "stray read data")
  `ASSERT_IMPLIES(a_drain_has_data, state_q == ST_DRAIN, rd_vld_q, "drain without last pair")
  `ASSERT_NEXT(a_run_end, out_fire && out_data_o.last_of_run, state_q == ST_LOAD,
               "run did not return to load")

endmodule

### test/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for gaussian_paf_mod8_fingerprint: whole words of
// Gaussian-integer elements go in, and each shift's autocorrelation residues
// are predicted and checked in order, with random idling on both channels.
// ---------------------------------------------------------------------------
module tb;
  import gpaf_pkg::*;

  localparam int WordLen   = 21;
  localparam int NumShifts = 10;
  localparam int RandWords = 11;
  localparam int TailWords = 2;

  class corr_scoreboard;
    logic signed [3:0] word_re[WordLen];
    logic signed [3:0] word_im[WordLen];
    int   loaded;
    out_t expected_corr_q[$];
    int   errors;
    int   checked;
    int   words;

    function new();
      loaded  = 0;
      errors  = 0;
      checked = 0;
      words   = 0;
    endfunction

    task report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    function void predict_word();
      int   acc_re;
      int   acc_im;
      int   q;
      out_t r;
      for (int s = 1; s <= NumShifts; s++) begin
        acc_re = 0;
        acc_im = 0;
        for (int p = 0; p < WordLen; p++) begin
          q = (p + s) % WordLen;
          acc_re += int'(word_re[p]) * int'(word_re[q]) + int'(word_im[p]) * int'(word_im[q]);
          acc_im += int'(word_im[p]) * int'(word_re[q]) - int'(word_re[p]) * int'(word_im[q]);
        end
        r.shift_index  = 4'(s);
        r.corr_re_mod8 = acc_re[2:0];
        r.corr_im_mod8 = acc_im[2:0];
        r.last_of_run  = (s == NumShifts);
        expected_corr_q = {expected_corr_q, r};
      end
    endfunction

    function void note_element(input in_t d);
      word_re[loaded] = d.elem_re;
      word_im[loaded] = d.elem_im;
      loaded++;
      if (loaded == WordLen) begin
        loaded = 0;
        words++;
        predict_word();
      end
    endfunction

    task check_result(input out_t got);
      out_t exp_r;
      if (expected_corr_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", got));
      end else begin
        exp_r = expected_corr_q.pop_front();
        checked++;
        if (got.shift_index !== exp_r.shift_index)
          report_mismatch($sformatf("shift_index %0d, want %0d",
                                    got.shift_index, exp_r.shift_index));
        if (got.corr_re_mod8 !== exp_r.corr_re_mod8)
          report_mismatch($sformatf("shift %0d corr_re_mod8 %0d, want %0d",
                                    exp_r.shift_index, got.corr_re_mod8, exp_r.corr_re_mod8));
        if (got.corr_im_mod8 !== exp_r.corr_im_mod8)
          report_mismatch($sformatf("shift %0d corr_im_mod8 %0d, want %0d",
                                    exp_r.shift_index, got.corr_im_mod8, exp_r.corr_im_mod8));
        if (got.last_of_run !== exp_r.last_of_run)
          report_mismatch($sformatf("shift %0d last_of_run %0b, want %0b",
                                    exp_r.shift_index, got.last_of_run, exp_r.last_of_run));
      end
    endtask

    function int pending();
      return expected_corr_q.size();
    endfunction
  endclass

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready_o;
  in_t  in_data   = '0;
  logic out_valid_o;
  logic out_ready = 1'b1;
  out_t out_data_o;
  bit   quiet_tail = 1'b0;

  corr_scoreboard sb = new();

  gaussian_paf_mod8_fingerprint #(
    .WORD_LENGTH(WordLen),
    .NUM_SHIFTS (NumShifts)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #(12 * 120000);
    $display("** gaussian_paf_mod8_fingerprint: FAILED **");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready)
      sb.check_result(out_data_o);
  end

  // result-side back-pressure
  initial begin
    forever begin
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      if (!quiet_tail && $urandom_range(0, 1) == 1) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_element(input int re, input int im, input bit eager);
    in_t d;
    d.elem_re = re[3:0];
    d.elem_im = im[3:0];
    if (!eager && !quiet_tail && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_element(d);
  endtask

  // mode: full range, extremes only, or mostly zero
  task automatic send_word(input int mode);
    int re;
    int im;
    bit eager;
    eager = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < WordLen; k++) begin
      case (mode)
        1: begin
          re = $urandom_range(0, 1) ? 7 : -8;
          im = $urandom_range(0, 1) ? 7 : -8;
        end
        2: begin
          re = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 15)) - 8 : 0;
          im = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 15)) - 8 : 0;
        end
        default: begin
          re = int'($urandom_range(0, 15)) - 8;
          im = int'($urandom_range(0, 15)) - 8;
        end
      endcase
      send_element(re, im, eager);
    end
  endtask

  initial begin
    int dir_re[WordLen] = '{-8, 7, -8, 7, 0, -1, 1, 0, -8, -8, 7,
                            7, 3, -4, 5, -6, 2, -3, 0, -8, 7};
    int dir_im[WordLen] = '{-8, 7, 7, -8, 0, -1, 0, 1, -8, -8, 7,
                            -8, -5, 6, -2, 4, -7, 1, 0, 7, -8};
    int mode;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < WordLen; k++)
      send_element(dir_re[k], dir_im[k], 1'b0);

    for (int w = 0; w < RandWords; w++) begin
      if (w == RandWords - TailWords)
        quiet_tail = 1'b1;
      mode = $urandom_range(0, 5);
      send_word(mode < 4 ? 0 : mode - 3);
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Loaded %0d words (extreme, sparse and full-range elements) with idling on",
             sb.words);
    $display("both channels; %0d shift results checked, %0d mismatches.",
             sb.checked, sb.errors);
    if (sb.errors == 0)
      $display("** gaussian_paf_mod8_fingerprint: PASSED **");
    else
      $display("** gaussian_paf_mod8_fingerprint: FAILED **");
    $finish;
  end

endmodule
